[rtl/core/l4cs_pkg.sv]
package l4cs_pkg;

    // Packet kinds carried on tuser
    localparam logic [1:0] ACT_IPV4 = 2'd0;
    localparam logic [1:0] ACT_IPV6 = 2'd1;
    localparam logic [1:0] ACT_NONE = 2'd2;

    localparam int DEFAULT_MAX_PACKET_BYTES = 16384;

    // Word positions of the fields that feed the pseudo header
    localparam int IPV4_LEN_WORD   = 0;
    localparam int IPV4_PROTO_WORD = 2;
    localparam int IPV4_SRC_WORD   = 3;
    localparam int IPV4_DST_WORD   = 4;
    localparam int IPV6_LEN_WORD   = 5 - 4;
    localparam int IPV6_ADDR_FIRST = 2;
    localparam int IPV6_ADDR_LAST  = 9;
    localparam int IP_HDR_WORDS    = 5;

    // Fixed IPv4 header length taken off the total length
    localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;

    // Partial sums of one word, before the end-around fold
    typedef struct packed {
        logic [16:0] hdr_part;
        logic [17:0] l4_part;
    } word_terms_t;

    // Fold a sum of up to eight 16-bit terms to 16 bits with end-around carry
    function automatic logic [15:0] csum_fold(input logic [18:0] s);
        logic [16:0] t;
        logic [15:0] r;
        t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        r = t[15:0] + {15'd0, t[16]};
        return r;
    endfunction

endpackage

[rtl/core/l4_checksum_with_pseudo_header.sv]
// Transport checksum with pseudo header over a packet stream.
// Slave side: one 32-bit packet word per handshake, network order, starting
// at the IP header. tuser gives the packet kind (IPv4, IPv6, or no pseudo
// header), tlast marks the final word, tdata carries the word, its count of
// valid leading bytes and the byte offset of the transport header.
// Master side: one result word per packet, holding the complemented
// transport checksum and the complemented IPv4 header check (zero when the
// first 20 bytes form a valid header).
// Throughput: one word every cycle unless a last word waits; the accumulate
// step is one short adder tree and fold between the input and sum registers.
// Result path: a last word is held in the input register, then its result is registered.
// Reset: clears the word position, both sums and all valid flags.
// Stall: a waiting result holds in the output register; words that are not
// last keep flowing, and only a last word waits for the result to be taken.
module l4_checksum_with_pseudo_header #(
    parameter int MAX_PACKET_BYTES = l4cs_pkg::DEFAULT_MAX_PACKET_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] data, [34:32] bytes_valid, [44:35] l4_start, [47:45] zero
    input  logic [47:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] l4_checksum, [31:16] ip_header_check
    output logic [31:0] m_tdata
);

    localparam int POS_LIMIT = (MAX_PACKET_BYTES + 3) / 4;
    localparam int POS_W     = $clog2(POS_LIMIT + 1);

    // Input register: hold one word ahead of the accumulators
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [1:0]            in_action_reg;
    logic [31:0]           in_data_reg;
    logic [2:0]            in_bv_reg;
    logic [9:0]            in_l4_start_reg;
    logic                  in_last_reg;
    logic                  advance;
    logic                  can_close;
    logic [POS_W-1:0]      pos;
    l4cs_pkg::word_terms_t terms;

    // A non-last word never produces a result, so it always moves on;
    // a last word waits for the output register to be free.
    assign advance  = in_valid_reg && (!in_last_reg || can_close);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            in_action_reg   <= s_tuser;
            in_data_reg     <= s_tdata[31:0];
            in_bv_reg       <= s_tdata[34:32];
            in_l4_start_reg <= s_tdata[44:35];
            in_last_reg     <= s_tlast;
        end
    end

    // Per-word contributions to the header and transport sums
    l4cs_word_terms #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_terms (
        .action      (in_action_reg),
        .data        (in_data_reg),
        .bytes_valid (in_bv_reg),
        .l4_start    (in_l4_start_reg),
        .pos         (pos),
        .terms       (terms)
    );

    // Running sums, word position and the result register
    l4cs_accum #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item_last (in_last_reg),
        .terms     (terms),
        .pos       (pos),
        .can_close (can_close),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/core/l4cs_word_terms.sv]
module l4cs_word_terms #(
    parameter int MAX_PACKET_BYTES = l4cs_pkg::DEFAULT_MAX_PACKET_BYTES,
    localparam int POS_LIMIT = (MAX_PACKET_BYTES + 3) / 4,
    localparam int POS_W = $clog2(POS_LIMIT + 1)
) (
    input  logic [1:0]             action,
    input  logic [31:0]            data,
    input  logic [2:0]             bytes_valid,
    input  logic [9:0]             l4_start,
    input  logic [POS_W-1:0]       pos,
    output l4cs_pkg::word_terms_t  terms
);

    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

    logic [31:0]      mask;
    logic [31:0]      w;
    logic [15:0]      w_hi;
    logic [15:0]      w_lo;
    logic [16:0]      halves;
    logic [17:0]      pseudo;
    logic [17:0]      xport;
    logic             in_range;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] l4_word_ext;

    always_comb begin
        unique case (bytes_valid)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'hff00_0000;
            3'd2:    mask = 32'hffff_0000;
            3'd3:    mask = 32'hffff_ff00;
            default: mask = 32'hffff_ffff;
        endcase
    end

    assign w      = data & mask;
    assign w_hi   = w[31:16];
    assign w_lo   = w[15:0];
    assign halves = {1'b0, w_hi} + {1'b0, w_lo};

    assign in_range    = pos < POS_W'(POS_LIMIT);
    assign pos_ext     = CMP_W'(pos);
    assign l4_word_ext = CMP_W'(l4_start[9:2]);

    // Pseudo header contribution of this word
    always_comb begin
        pseudo = 18'd0;
        unique case (action)
            l4cs_pkg::ACT_IPV4: begin
                if (pos == POS_W'(l4cs_pkg::IPV4_LEN_WORD)) begin
                    pseudo = {2'd0, w_lo - l4cs_pkg::IPV4_HDR_BYTES};
                end else if (pos == POS_W'(l4cs_pkg::IPV4_PROTO_WORD)) begin
                    pseudo = {10'd0, w[23:16]};
                end else if (pos == POS_W'(l4cs_pkg::IPV4_SRC_WORD) ||
                             pos == POS_W'(l4cs_pkg::IPV4_DST_WORD)) begin
                    pseudo = {1'b0, halves};
                end
            end
            l4cs_pkg::ACT_IPV6: begin
                if (pos == POS_W'(l4cs_pkg::IPV6_LEN_WORD)) begin
                    pseudo = {2'd0, w_hi} + {10'd0, w[15:8]};
                end else if (pos >= POS_W'(l4cs_pkg::IPV6_ADDR_FIRST) &&
                             pos <= POS_W'(l4cs_pkg::IPV6_ADDR_LAST)) begin
                    pseudo = {1'b0, halves};
                end
            end
            default: pseudo = 18'd0;
        endcase
    end

    assign xport = (pos_ext >= l4_word_ext) ? {1'b0, halves} : 18'd0;

    always_comb begin
        terms.hdr_part = 17'd0;
        terms.l4_part  = 18'd0;
        if (in_range) begin
            if (pos < POS_W'(l4cs_pkg::IP_HDR_WORDS)) begin
                terms.hdr_part = halves;
            end
            terms.l4_part = pseudo + xport;
        end
    end

endmodule

[rtl/core/l4cs_accum.sv]
module l4cs_accum #(
    parameter int MAX_PACKET_BYTES = l4cs_pkg::DEFAULT_MAX_PACKET_BYTES,
    localparam int POS_LIMIT = (MAX_PACKET_BYTES + 3) / 4,
    localparam int POS_W = $clog2(POS_LIMIT + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  item_last,
    input  l4cs_pkg::word_terms_t terms,
    output logic [POS_W-1:0]      pos,
    output logic                  can_close,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      hdr_sum_reg;
    logic [15:0]      hdr_sum_next;
    logic [15:0]      l4_sum_reg;
    logic [15:0]      l4_sum_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [31:0]      m_data_reg;
    logic [31:0]      m_data_next;
    logic [15:0]      hdr_new;
    logic [15:0]      l4_new;

    assign hdr_new = l4cs_pkg::csum_fold({3'd0, hdr_sum_reg} + {2'd0, terms.hdr_part});
    assign l4_new  = l4cs_pkg::csum_fold({3'd0, l4_sum_reg} + {1'b0, terms.l4_part});

    always_comb begin
        pos_next     = pos_reg;
        hdr_sum_next = hdr_sum_reg;
        l4_sum_next  = l4_sum_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            if (item_last) begin
                // close the packet: emit and clear
                pos_next     = '0;
                hdr_sum_next = 16'd0;
                l4_sum_next  = 16'd0;
                m_valid_next = 1'b1;
                m_data_next  = {~hdr_new, ~l4_new};
            end else begin
                hdr_sum_next = hdr_new;
                l4_sum_next  = l4_new;
                if (pos_reg < POS_W'(POS_LIMIT)) begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            hdr_sum_reg <= 16'd0;
            l4_sum_reg  <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            hdr_sum_reg <= hdr_sum_next;
            l4_sum_reg  <= l4_sum_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign pos       = pos_reg;
    assign can_close = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

endmodule

[bench/l4_checksum_with_pseudo_header_test.sv]
`timescale 1ns / 100ps

module l4_checksum_with_pseudo_header_test;

    // Action value the package leaves unnamed; the block treats it like ACT_NONE
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int         MAX_WORDS    = l4cs_pkg::DEFAULT_MAX_PACKET_BYTES / 4;
    localparam int         RANDOM_WORDS = 1800;

    // One result word: [15:0] l4_checksum, [31:16] ip_header_check
    typedef struct packed {
        logic [15:0] ip_hdr_check;
        logic [15:0] l4_check;
    } csum_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [31:0] data, [34:32] bytes_valid, [44:35] l4_start, [47:45] zero
    logic [47:0] s_tdata  = '0;
    // [1:0] action
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] l4_checksum, [31:16] ip_header_check
    logic [31:0] m_tdata;

    // Running copy of the block's state
    int          pkt_pos  = 0;
    logic [15:0] l4_acc   = '0;
    logic [15:0] hdr_acc  = '0;

    csum_result_t csum_pending[$];

    int  mismatch_count = 0;
    int  word_count     = 0;
    int  pkt_count      = 0;
    int  checked_count  = 0;
    int  stall_cycles   = 0;
    bit  tx_gaps_on     = 1'b1;
    int  rx_hold_req    = 0;
    bit  rx_holding     = 1'b0;

    l4_checksum_with_pseudo_header dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // End-around carry add of one 16-bit term; a single fold is enough as
    // the accumulator never exceeds 16 bits
    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, v};
        s = {1'b0, s[15:0]} + {16'd0, s[16]};
        return s[15:0];
    endfunction

    function automatic logic [15:0] ones_add_word(input logic [15:0] acc,
                                                  input logic [31:0] w);
        return ones_add(ones_add(acc, w[31:16]), w[15:0]);
    endfunction

    // Advance the checksum state by one accepted word; queue the result on last
    function automatic void csum_track(input logic [1:0] act, input logic [31:0] data,
                                       input logic [2:0] bv, input logic last,
                                       input logic [9:0] l4_start);
        logic [31:0]  mask;
        logic [31:0]  w;
        int           l4_word;
        csum_result_t r;
        case (bv)
            3'd0: mask = 32'h0000_0000;
            3'd1: mask = 32'hff00_0000;
            3'd2: mask = 32'hffff_0000;
            3'd3: mask = 32'hffff_ff00;
            default: mask = 32'hffff_ffff;
        endcase
        w       = data & mask;
        l4_word = int'(l4_start[9:2]);

        // Words past the size limit leave the state alone
        if (pkt_pos < MAX_WORDS) begin
            if (pkt_pos < l4cs_pkg::IP_HDR_WORDS)
                hdr_acc = ones_add_word(hdr_acc, w);

            if (act == l4cs_pkg::ACT_IPV4) begin
                if (pkt_pos == l4cs_pkg::IPV4_LEN_WORD)
                    l4_acc = ones_add(l4_acc, w[15:0] - l4cs_pkg::IPV4_HDR_BYTES);
                else if (pkt_pos == l4cs_pkg::IPV4_PROTO_WORD)
                    l4_acc = ones_add(l4_acc, {8'd0, w[23:16]});
                else if (pkt_pos == l4cs_pkg::IPV4_SRC_WORD ||
                         pkt_pos == l4cs_pkg::IPV4_DST_WORD)
                    l4_acc = ones_add_word(l4_acc, w);
            end else if (act == l4cs_pkg::ACT_IPV6) begin
                if (pkt_pos == l4cs_pkg::IPV6_LEN_WORD) begin
                    l4_acc = ones_add(l4_acc, w[31:16]);
                    l4_acc = ones_add(l4_acc, {8'd0, w[15:8]});
                end else if (pkt_pos >= l4cs_pkg::IPV6_ADDR_FIRST &&
                             pkt_pos <= l4cs_pkg::IPV6_ADDR_LAST) begin
                    l4_acc = ones_add_word(l4_acc, w);
                end
            end

            if (pkt_pos >= l4_word)
                l4_acc = ones_add_word(l4_acc, w);

            pkt_pos++;
        end

        if (last) begin
            r.l4_check     = ~l4_acc;
            r.ip_hdr_check = ~hdr_acc;
            csum_pending.push_back(r);
            pkt_count++;
            pkt_pos = 0;
            l4_acc  = '0;
            hdr_acc = '0;
        end
    endfunction

    // Offer one word, after an optional gap, and hold it until taken.
    // Called at a rising edge; returns at the edge that accepted the word.
    task automatic send_word(input logic [1:0] act, input logic [31:0] data,
                             input logic [2:0] bv, input logic last,
                             input logic [9:0] l4_start);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (tx_gaps_on) begin
            if (pick >= 98)
                gap = $urandom_range(20, 50);
            else if (pick >= 90)
                gap = $urandom_range(4, 10);
            else if (pick >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, l4_start, bv, data};
        s_tuser  <= act;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        csum_track(act, data, bv, last, l4_start);
        word_count++;
    endtask

    // Drop valid and hold until every queued result has been checked,
    // then allow for the output pipeline to settle
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (csum_pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Header of all ones: the header sum saturates at 0xffff
    task automatic test_ipv4_all_ones;
        for (int i = 0; i < 6; i++)
            send_word(l4cs_pkg::ACT_IPV4, 32'hffff_ffff, 3'd4, i == 5, 10'd20);
        wait_for_results();
    endtask

    // IPv6 header whose transport start lies past the end of the packet,
    // so the transport sum holds the pseudo header only; odd tail of 3 bytes
    task automatic test_ipv6_beyond_end;
        for (int i = 0; i < 10; i++)
            send_word(l4cs_pkg::ACT_IPV6, (i == 0) ? 32'h0 : 32'($urandom()),
                      (i == 9) ? 3'd3 : 3'd4, i == 9, 10'd1020);
        wait_for_results();
    endtask

    // Single-word packets: no pseudo header, and the reserved action with
    // an empty word and the largest transport offset
    task automatic test_odd_kinds;
        send_word(l4cs_pkg::ACT_NONE, 32'hffff_ffff, 3'd2, 1'b1, 10'd0);
        send_word(ACT_RESERVED, 32'($urandom()), 3'd0, 1'b1, 10'h3ff);
        wait_for_results();
    endtask

    // Byte counts above four, a short word that is not last, an empty last
    // word, unaligned and changing transport offsets, and the action
    // changing from word to word
    task automatic test_odd_words;
        send_word(l4cs_pkg::ACT_IPV4, 32'($urandom()), 3'd5, 1'b0, 10'd0);
        send_word(l4cs_pkg::ACT_IPV6, 32'($urandom()), 3'd1, 1'b0, 10'd6);
        send_word(l4cs_pkg::ACT_NONE, 32'($urandom()), 3'd6, 1'b0, 10'd8);
        send_word(ACT_RESERVED,       32'($urandom()), 3'd7, 1'b0, 10'd1023);
        send_word(l4cs_pkg::ACT_IPV4, 32'($urandom()), 3'd0, 1'b1, 10'd12);
        wait_for_results();
    endtask

    // Packet longer than the size limit: the tail past the limit is ignored
    // but the last word must still be answered
    task automatic test_oversize_packet;
        int n;
        n = MAX_WORDS + 4;
        for (int i = 0; i < n; i++)
            send_word(l4cs_pkg::ACT_IPV4, 32'($urandom()), 3'd4, i == n - 1, 10'd20);
        wait_for_results();
    endtask

    // Hold the result side off for a long stretch while short packets keep
    // arriving back to back, so a second last word has to wait at the input
    task automatic test_result_stall;
        rx_hold_req = 400;
        while (!rx_holding) @(posedge aclk);
        tx_gaps_on = 1'b0;
        for (int p = 0; p < 6; p++)
            for (int i = 0; i < 3; i++)
                send_word((p % 2 == 0) ? l4cs_pkg::ACT_IPV4 : l4cs_pkg::ACT_NONE,
                          32'($urandom()), 3'd4, i == 2, 10'd8);
        tx_gaps_on = 1'b1;
        wait_for_results();
    endtask

    // Mostly well-formed IPv4, IPv6 and ICMP packets with random content;
    // some truncated, some with noisy words, some pure noise
    task automatic test_random_traffic;
        byte unsigned pkt[$];
        int           start_words;
        int           kind;
        int           hlen;
        int           plen;
        int           len;
        int           nwords;
        int           idx;
        bit           noisy;
        logic [1:0]   act;
        logic [1:0]   wact;
        logic [9:0]   l4;
        logic [9:0]   wl4;
        logic [2:0]   bv;
        logic [31:0]  data;
        logic [15:0]  total;
        logic [15:0]  hsum;
        logic [7:0]   proto;

        start_words = word_count;
        while (word_count - start_words < RANDOM_WORDS) begin
            pkt.delete();
            kind  = $urandom_range(0, 99);
            noisy = ($urandom_range(0, 99) < 15);
            if (kind < 35)
                act = l4cs_pkg::ACT_IPV4;
            else if (kind < 65)
                act = l4cs_pkg::ACT_IPV6;
            else if (kind < 85)
                act = l4cs_pkg::ACT_NONE;
            else if (kind < 92)
                act = ACT_RESERVED;
            else
                act = 2'($urandom_range(0, 3));

            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1500)
                                                : $urandom_range(0, 64);
            if (act == l4cs_pkg::ACT_IPV6)
                hlen = 40;
            else
                hlen = ($urandom_range(0, 3) == 0) ? 4 * $urandom_range(5, 15) : 20;
            len = hlen + plen;
            for (int i = 0; i < len; i++)
                pkt.push_back(8'($urandom()));

            case ($urandom_range(0, 3))
                0: proto = 8'd6;
                1: proto = 8'd17;
                2: proto = 8'd58;
                default: proto = 8'($urandom());
            endcase

            // Lay out a plausible IP header
            if (act == l4cs_pkg::ACT_IPV6) begin
                pkt[0] = 8'h60 | (pkt[0] & 8'h0f);
                pkt[4] = 8'(plen >> 8);
                pkt[5] = 8'(plen);
                pkt[6] = proto;
            end else begin
                total  = 16'(len);
                pkt[0] = {4'h4, 4'(hlen / 4)};
                pkt[2] = total[15:8];
                pkt[3] = total[7:0];
                pkt[9] = (act == l4cs_pkg::ACT_NONE) ? 8'd1 : proto;
                // Give most headers a correct header checksum
                if ($urandom_range(0, 99) < 60) begin
                    pkt[10] = 8'd0;
                    pkt[11] = 8'd0;
                    hsum = '0;
                    for (int k = 0; k < 10; k++)
                        hsum = ones_add(hsum, {pkt[2 * k], pkt[2 * k + 1]});
                    hsum    = ~hsum;
                    pkt[10] = hsum[15:8];
                    pkt[11] = hsum[7:0];
                end
            end
            l4 = 10'(hlen);

            // Truncate a few packets inside the header; scramble the noise ones
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(0, hlen - 1);
            if (kind >= 92) begin
                len = $urandom_range(0, 100);
                l4  = 10'($urandom());
            end
            while (pkt.size() > len)
                void'(pkt.pop_back());
            len = pkt.size();

            nwords = (len + 3) / 4;
            if (nwords == 0)
                nwords = 1;
            for (int w = 0; w < nwords; w++) begin
                // Bytes past the end carry junk that must be masked off
                data = $urandom();
                for (int k = 0; k < 4; k++) begin
                    idx = 4 * w + k;
                    if (idx < len)
                        data[31 - 8 * k -: 8] = pkt[idx];
                end
                bv   = (w == nwords - 1) ? 3'(len - 4 * w) : 3'd4;
                wact = act;
                wl4  = l4;
                if (noisy) begin
                    if ($urandom_range(0, 9) == 0)
                        wact = 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0)
                        wl4 = 10'($urandom());
                    if ($urandom_range(0, 11) == 0)
                        bv = 3'($urandom_range(0, 7));
                end
                send_word(wact, data, bv, w == nwords - 1, wl4);
            end

            // Now and then let everything drain before the next packet
            if ($urandom_range(0, 19) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // Result side pacing: runs of ready with gaps, mostly short, a few long,
    // plus the long hold that a test asks for
    initial begin
        int run_len;
        int gap;
        int hold;
        int pick;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req > 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
                rx_holding  = 1'b1;
                m_tready   <= 1'b0;
                repeat (hold) @(posedge aclk);
                rx_holding  = 1'b0;
            end
            pick    = $urandom_range(0, 99);
            run_len = (pick < 10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            pick = $urandom_range(0, 99);
            if (pick >= 96)
                gap = $urandom_range(20, 60);
            else if (pick >= 40)
                gap = $urandom_range(1, 3);
            else
                gap = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Compare every result word with the oldest queued checksum pair
    always @(posedge aclk) begin
        csum_result_t want;
        csum_result_t got;
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                stall_cycles++;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (csum_pending.size() == 0) begin
                    $display("%0t: unexpected result word, actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = csum_pending.pop_front();
                    checked_count++;
                    if (got.l4_check !== want.l4_check) begin
                        $display("%0t: l4_checksum expected %h actual %h",
                                 $time, want.l4_check, got.l4_check);
                        mismatch_count++;
                    end
                    if (got.ip_hdr_check !== want.ip_hdr_check) begin
                        $display("%0t: ip_header_check expected %h actual %h",
                                 $time, want.ip_hdr_check, got.ip_hdr_check);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, csum_pending.size());
        $display("FAIL l4_checksum_with_pseudo_header");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ipv4_all_ones();
        test_ipv6_beyond_end();
        test_odd_kinds();
        test_odd_words();
        test_oversize_packet();
        test_result_stall();
        test_random_traffic();

        if (csum_pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, csum_pending.size());
            mismatch_count++;
        end

        $display("Sent %0d packets in %0d words: IPv4, IPv6, ICMP, reserved kinds, noise",
                 pkt_count, word_count);
        $display("Checked %0d results, one oversize packet, input held off %0d cycles",
                 checked_count, stall_cycles);
        if (mismatch_count == 0)
            $display("PASS l4_checksum_with_pseudo_header");
        else
            $display("FAIL l4_checksum_with_pseudo_header");
        $finish;
    end

endmodule
